// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/can_afb_pkg.sv =====
package can_afb_pkg;

   localparam int ID_W    = 29;
   localparam int TAG_W   = 16;
   localparam int SLOT_W  = 8;
   localparam int INDEX_W = 5;
   localparam int LEN_W   = 4;
   localparam int DATA_W  = 64;

   typedef enum logic [1:0] {
      MODE_MATCH    = 2'd0,
      MODE_SET_SLOT = 2'd1,
      MODE_SET_FREE = 2'd2,
      MODE_CLEAR    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_FRAME   = 2'd0,
      KIND_SET     = 2'd1,
      KIND_REJECT  = 2'd2,
      KIND_CLEARED = 2'd3
   } kind_type;

   // -1 in the five-bit signed result index
   localparam logic [INDEX_W-1:0] NO_INDEX = '1;

   typedef struct packed {
      logic             ext;
      logic [ID_W-1:0]  id;     // held already ANDed with mask
      logic [ID_W-1:0]  mask;
      logic [TAG_W-1:0] tag;
   } filter_type;

   typedef struct packed {
      logic       wr_en;
      logic       clear;
      filter_type entry;
   } bank_wr_type;

endpackage

// ===== rtl/can_afb_bank.sv =====
module can_afb_bank #(
   parameter int NUM_FILTERS = 16,
   parameter int IDX_W       = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  can_afb_pkg::bank_wr_type wr,
   input  logic [IDX_W-1:0]         wr_idx,
   output logic [NUM_FILTERS-1:0]   valid,
   output can_afb_pkg::filter_type  filters [NUM_FILTERS]
);

   logic [NUM_FILTERS-1:0]  valid_ff;
   logic [NUM_FILTERS-1:0]  valid_in;
   can_afb_pkg::filter_type entry_ff [NUM_FILTERS];

   always_comb begin
      valid_in = valid_ff;
      if (wr.clear) begin
         valid_in = '0;
      end else if (wr.wr_en) begin
         for (int i = 0; i < NUM_FILTERS; i++) begin
            if (wr_idx == IDX_W'(i)) begin
               valid_in[i] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Entry contents only matter while the valid flag is set
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_FILTERS; i++) begin
         if (wr.wr_en && wr_idx == IDX_W'(i)) begin
            entry_ff[i] <= wr.entry;
         end
      end
   end

   assign valid   = valid_ff;
   assign filters = entry_ff;

endmodule

// ===== rtl/can_afb_match.sv =====
module can_afb_match #(
   parameter int NUM_FILTERS = 16,
   parameter int IDX_W       = 4
) (
   input  logic [NUM_FILTERS-1:0]            valid,
   input  can_afb_pkg::filter_type           filters [NUM_FILTERS],
   input  logic [can_afb_pkg::ID_W-1:0]      frame_id,
   input  logic                              is_extended,
   output logic                              hit,
   output logic [IDX_W-1:0]                  hit_idx,
   output logic [can_afb_pkg::TAG_W-1:0]     hit_tag,
   output logic                              free,
   output logic [IDX_W-1:0]                  free_idx
);

   // Compare all filters in parallel; walking down leaves the lowest index
   always_comb begin
      hit      = 1'b0;
      hit_idx  = '0;
      hit_tag  = '0;
      free     = 1'b0;
      free_idx = '0;
      for (int i = NUM_FILTERS - 1; i >= 0; i--) begin
         if (valid[i] && ((frame_id & filters[i].mask) == filters[i].id) &&
             (filters[i].ext == is_extended)) begin
            hit     = 1'b1;
            hit_idx = IDX_W'(i);
            hit_tag = filters[i].tag;
         end
         if (!valid[i]) begin
            free     = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

endmodule

// ===== rtl/can_acceptance_filter_bank.sv =====
// Order: a command is held in the input register, then its result in the result
// register. Throughput: one command per cycle while the result register is not
// stalled; a frame dropped with delivery off leaves without a result, even during a stall.
// Reset (synchronous, active high) clears all filter valid flags, delivery enable
// and both pipeline valid flags.
`include "assert_macros.svh"

module can_acceptance_filter_bank #(
   parameter int NUM_FILTERS = 16
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               csr_wr_en,
   input  logic               csr_wr_data,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic [7:0]         req_slot,
   input  logic [28:0]        req_frame_id,
   input  logic [28:0]        req_id_mask,
   input  logic               req_is_extended,
   input  logic               req_is_remote,
   input  logic [3:0]         req_length_code,
   input  logic [63:0]        req_payload,
   input  logic signed [15:0] req_handler_tag,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_result_kind,
   output logic signed [4:0]  rsp_result_index,
   output logic [28:0]        rsp_out_id,
   output logic               rsp_out_extended,
   output logic               rsp_out_remote,
   output logic [3:0]         rsp_out_length,
   output logic [63:0]        rsp_out_payload,
   output logic signed [15:0] rsp_out_tag
);

   localparam int IDX_W  = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
   localparam int WIDE_W = IDX_W + can_afb_pkg::INDEX_W;
   localparam logic [can_afb_pkg::SLOT_W:0] SLOT_LIMIT =
      (can_afb_pkg::SLOT_W + 1)'(NUM_FILTERS);

   // configuration
   logic delivery_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delivery_en_ff <= 1'b0;
      end else if (csr_wr_en) begin
         delivery_en_ff <= csr_wr_data;
      end
   end

   // input register
   logic                                s1_valid_ff;
   logic                                s1_valid_in;
   can_afb_pkg::mode_type               s1_mode_ff;
   logic [can_afb_pkg::SLOT_W-1:0]      s1_slot_ff;
   logic [can_afb_pkg::ID_W-1:0]        s1_id_ff;
   logic [can_afb_pkg::ID_W-1:0]        s1_mask_ff;
   logic                                s1_ext_ff;
   logic                                s1_remote_ff;
   logic [can_afb_pkg::LEN_W-1:0]       s1_len_ff;
   logic [can_afb_pkg::DATA_W-1:0]      s1_payload_ff;
   logic [can_afb_pkg::TAG_W-1:0]       s1_tag_ff;

   logic s1_emit;
   logic s1_go;
   logic req_take;

   // result register
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   can_afb_pkg::kind_type               rsp_kind_ff;
   can_afb_pkg::kind_type               rsp_kind_in;
   logic [can_afb_pkg::INDEX_W-1:0]     rsp_index_ff;
   logic [can_afb_pkg::INDEX_W-1:0]     rsp_index_in;
   logic [can_afb_pkg::ID_W-1:0]        rsp_id_ff;
   logic [can_afb_pkg::ID_W-1:0]        rsp_id_in;
   logic                                rsp_ext_ff;
   logic                                rsp_ext_in;
   logic                                rsp_remote_ff;
   logic                                rsp_remote_in;
   logic [can_afb_pkg::LEN_W-1:0]       rsp_len_ff;
   logic [can_afb_pkg::LEN_W-1:0]       rsp_len_in;
   logic [can_afb_pkg::DATA_W-1:0]      rsp_payload_ff;
   logic [can_afb_pkg::DATA_W-1:0]      rsp_payload_in;
   logic [can_afb_pkg::TAG_W-1:0]       rsp_tag_ff;
   logic [can_afb_pkg::TAG_W-1:0]       rsp_tag_in;

   // filter bank and matcher
   can_afb_pkg::bank_wr_type            bank_wr;
   logic [IDX_W-1:0]                    bank_wr_idx;
   logic [NUM_FILTERS-1:0]              filt_valid;
   can_afb_pkg::filter_type             filters [NUM_FILTERS];
   logic                                hit;
   logic [IDX_W-1:0]                    hit_idx;
   logic [can_afb_pkg::TAG_W-1:0]       hit_tag;
   logic                                free;
   logic [IDX_W-1:0]                    free_idx;
   logic [WIDE_W-1:0]                   hit_wide;
   logic [WIDE_W-1:0]                   free_wide;
   logic                                slot_ok;

   can_afb_bank #(
      .NUM_FILTERS (NUM_FILTERS),
      .IDX_W       (IDX_W)
   ) u_bank (
      .clock   (clock),
      .reset   (reset),
      .wr      (bank_wr),
      .wr_idx  (bank_wr_idx),
      .valid   (filt_valid),
      .filters (filters)
   );

   can_afb_match #(
      .NUM_FILTERS (NUM_FILTERS),
      .IDX_W       (IDX_W)
   ) u_match (
      .valid       (filt_valid),
      .filters     (filters),
      .frame_id    (s1_id_ff),
      .is_extended (s1_ext_ff),
      .hit         (hit),
      .hit_idx     (hit_idx),
      .hit_tag     (hit_tag),
      .free        (free),
      .free_idx    (free_idx)
   );

   // handshake: a frame with delivery off leaves without a result
   assign s1_emit   = !(s1_mode_ff == can_afb_pkg::MODE_MATCH && !delivery_en_ff);
   assign s1_go     = s1_valid_ff && (!s1_emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff    <= can_afb_pkg::mode_type'(req_mode);
         s1_slot_ff    <= req_slot;
         s1_id_ff      <= req_frame_id;
         s1_mask_ff    <= req_id_mask;
         s1_ext_ff     <= req_is_extended;
         s1_remote_ff  <= req_is_remote;
         s1_len_ff     <= req_length_code;
         s1_payload_ff <= req_payload;
         s1_tag_ff     <= req_handler_tag;
      end
   end

   assign hit_wide  = WIDE_W'(hit_idx);
   assign free_wide = WIDE_W'(free_idx);
   assign slot_ok   = {1'b0, s1_slot_ff} < SLOT_LIMIT;

   // command decode; the bank is written as the command leaves the input register
   always_comb begin
      bank_wr.wr_en     = 1'b0;
      bank_wr.clear     = 1'b0;
      bank_wr.entry.ext = s1_ext_ff;
      bank_wr.entry.id  = s1_id_ff & s1_mask_ff;
      bank_wr.entry.mask = s1_mask_ff;
      bank_wr.entry.tag = s1_tag_ff;
      bank_wr_idx       = s1_slot_ff[IDX_W-1:0];

      rsp_kind_in    = can_afb_pkg::KIND_REJECT;
      rsp_index_in   = can_afb_pkg::NO_INDEX;
      rsp_id_in      = '0;
      rsp_ext_in     = 1'b0;
      rsp_remote_in  = 1'b0;
      rsp_len_in     = '0;
      rsp_payload_in = '0;
      rsp_tag_in     = '0;

      unique case (s1_mode_ff)
         can_afb_pkg::MODE_MATCH: begin
            rsp_kind_in    = can_afb_pkg::KIND_FRAME;
            rsp_index_in   = hit ? hit_wide[can_afb_pkg::INDEX_W-1:0]
                                 : can_afb_pkg::NO_INDEX;
            rsp_id_in      = s1_id_ff;
            rsp_ext_in     = s1_ext_ff;
            rsp_remote_in  = s1_remote_ff;
            rsp_len_in     = s1_len_ff;
            rsp_payload_in = s1_payload_ff;
            rsp_tag_in     = hit ? hit_tag : '0;
         end
         can_afb_pkg::MODE_SET_SLOT: begin
            if (slot_ok) begin
               bank_wr.wr_en = s1_go;
               rsp_kind_in   = can_afb_pkg::KIND_SET;
               rsp_index_in  = s1_slot_ff[can_afb_pkg::INDEX_W-1:0];
            end
         end
         can_afb_pkg::MODE_SET_FREE: begin
            if (free) begin
               bank_wr.wr_en = s1_go;
               bank_wr_idx   = free_idx;
               rsp_kind_in   = can_afb_pkg::KIND_SET;
               rsp_index_in  = free_wide[can_afb_pkg::INDEX_W-1:0];
            end
         end
         can_afb_pkg::MODE_CLEAR: begin
            bank_wr.clear = s1_go;
            rsp_kind_in   = can_afb_pkg::KIND_CLEARED;
            rsp_index_in  = '0;
         end
         default: begin
            rsp_kind_in = can_afb_pkg::KIND_REJECT;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && s1_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_emit) begin
         rsp_kind_ff    <= rsp_kind_in;
         rsp_index_ff   <= rsp_index_in;
         rsp_id_ff      <= rsp_id_in;
         rsp_ext_ff     <= rsp_ext_in;
         rsp_remote_ff  <= rsp_remote_in;
         rsp_len_ff     <= rsp_len_in;
         rsp_payload_ff <= rsp_payload_in;
         rsp_tag_ff     <= rsp_tag_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_out_id       = rsp_id_ff;
   assign rsp_out_extended = rsp_ext_ff;
   assign rsp_out_remote   = rsp_remote_ff;
   assign rsp_out_length   = rsp_len_ff;
   assign rsp_out_payload  = rsp_payload_ff;
   assign rsp_out_tag      = rsp_tag_ff;

   `ASSERT_IMP(a_reject_no_index, rsp_valid_ff && rsp_kind_ff == can_afb_pkg::KIND_REJECT, rsp_index_ff == can_afb_pkg::NO_INDEX, "rejected write without index -1")
   `ASSERT_IMP(a_ctrl_fields_zero, rsp_valid_ff && rsp_kind_ff != can_afb_pkg::KIND_FRAME, rsp_payload_ff == '0 && rsp_tag_ff == '0 && rsp_id_ff == '0, "control result carries frame data")
   `ASSERT_NXT(a_clear_empties, s1_go && s1_mode_ff == can_afb_pkg::MODE_CLEAR, filt_valid == '0, "filters still valid after clear")
   `ASSERT_IMP(a_stall_blocks_input, s1_valid_ff && s1_emit && rsp_valid_ff && !rsp_ready, !req_ready, "input taken while result stalled")

endmodule
